// ===== sv/lmcs_pkg.sv =====
// Package for the LED matrix column scanner: result type, scan phase codes,
// fixed widths and the digit glyph ROM. No dependencies.
package lmcs_pkg;

    localparam int ROW_W     = 8;
    localparam int COL_OUT_W = 5;
    localparam int SHOWN_W   = 14;
    localparam int DWELL_W   = 16;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd995;
    localparam logic [ROW_W-1:0]   ROW_BLANK   = 8'hFF;
    localparam logic [3:0]         DIGIT_MAX   = 4'd9;

    typedef enum logic [2:0] {
        PH_SEL_SHIFT = 3'd0,
        PH_SEL_LATCH = 3'd1,
        PH_DWELL     = 3'd2,
        PH_BLK_SHIFT = 3'd3,
        PH_BLK_LATCH = 3'd4
    } t_phase;

    typedef struct packed {
        logic                 serial_data;
        logic                 shift_clock;
        logic                 latch_clock;
        logic [ROW_W-1:0]     row_drive;
        logic [COL_OUT_W-1:0] active_column;
        logic [SHOWN_W-1:0]   shown_value;
        logic                 frame_done;
    } t_lmcs_res;

    localparam logic [ROW_W-1:0] GLYPH_ROM [10][8] = '{
        '{8'hFF, 8'h83, 8'h01, 8'h6D, 8'h75, 8'h01, 8'h83, 8'hFF},
        '{8'hFF, 8'h7F, 8'h77, 8'h01, 8'h01, 8'h7F, 8'h7F, 8'hFF},
        '{8'hFF, 8'h3B, 8'h19, 8'h5D, 8'h6D, 8'h61, 8'h73, 8'hFF},
        '{8'hFF, 8'hBB, 8'h39, 8'h6D, 8'h6D, 8'h01, 8'h93, 8'hFF},
        '{8'hFF, 8'hCF, 8'hD7, 8'hDB, 8'h01, 8'h01, 8'hDF, 8'hFF},
        '{8'hFF, 8'hB1, 8'h31, 8'h75, 8'h75, 8'h05, 8'h8D, 8'hFF},
        '{8'hFF, 8'h83, 8'h01, 8'h6D, 8'h6D, 8'h09, 8'h9B, 8'hFF},
        '{8'hFF, 8'hF9, 8'hF9, 8'h1D, 8'h05, 8'hE1, 8'hF9, 8'hFF},
        '{8'hFF, 8'h93, 8'h01, 8'h6D, 8'h6D, 8'h01, 8'h93, 8'hFF},
        '{8'hFF, 8'hB3, 8'h21, 8'h6D, 8'h6D, 8'h01, 8'h83, 8'hFF}
    };

    function automatic logic [ROW_W-1:0] glyph_line(input logic [3:0] digit,
                                                    input logic [2:0] line);
        if (digit > DIGIT_MAX) begin
            return ROW_BLANK;
        end
        return GLYPH_ROM[digit][line];
    endfunction

endpackage

// ===== sv/lmcs_in_if.sv =====
// Request channel of the LED matrix column scanner: valid, ready, advance.
// Depends on nothing.
interface lmcs_in_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink (input valid, input advance, output ready);
endinterface

// ===== sv/lmcs_out_if.sv =====
// Result channel of the LED matrix column scanner: valid, ready and pin levels.
// Depends on lmcs_pkg for the field widths.
interface lmcs_out_if import lmcs_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic                 serial_data;
    logic                 shift_clock;
    logic                 latch_clock;
    logic [ROW_W-1:0]     row_drive;
    logic [COL_OUT_W-1:0] active_column;
    logic [SHOWN_W-1:0]   shown_value;
    logic                 frame_done;

    modport source (output valid, output serial_data, output shift_clock,
                    output latch_clock, output row_drive, output active_column,
                    output shown_value, output frame_done, input ready);
    modport sink (input valid, input serial_data, input shift_clock,
                  input latch_clock, input row_drive, input active_column,
                  input shown_value, input frame_done, output ready);
endinterface

// ===== sv/led_matrix_counter_scanner_unit.sv =====
// LED matrix column scanner top level: scan core, output buffer, assertions.
// Depends on lmcs_pkg, lmcs_in_if, lmcs_out_if, lmcs_scan_core and lmcs_skid.
// Results are registered in the result register, or in the skid register while
// a finished result waits downstream. Throughput: one request per cycle while
// the skid register is empty, so a request is taken while one result waits.
// Reset (synchronous, active low): scan at column 0 in select shift, counter 0,
// rows blank, dwell 995 ticks, output buffer empty.
module led_matrix_counter_scanner_unit import lmcs_pkg::*; #(
    parameter int COLUMN_COUNT = 32,
    parameter int DIGIT_COUNT  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DWELL_W-1:0] i_cfg_data,
    lmcs_in_if.sink            i_req,
    lmcs_out_if.source         o_res
);

    t_lmcs_res core_res;
    t_lmcs_res buf_res;
    logic      req_ready;
    logic      accept;

    assign accept      = i_req.valid && req_ready;
    assign i_req.ready = req_ready;

    lmcs_scan_core #(
        .COLUMN_COUNT (COLUMN_COUNT),
        .DIGIT_COUNT  (DIGIT_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_advance  (i_req.advance),
        .o_res      (core_res)
    );

    lmcs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (req_ready),
        .i_data  (core_res),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (buf_res)
    );

    assign o_res.serial_data   = buf_res.serial_data;
    assign o_res.shift_clock   = buf_res.shift_clock;
    assign o_res.latch_clock   = buf_res.latch_clock;
    assign o_res.row_drive     = buf_res.row_drive;
    assign o_res.active_column = buf_res.active_column;
    assign o_res.shown_value   = buf_res.shown_value;
    assign o_res.frame_done    = buf_res.frame_done;

    a_full_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> o_res.valid)
        else $error("skid full without a valid result");

    a_clocks_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.shift_clock && o_res.latch_clock))
        else $error("shift and latch clocks high together");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done) |->
            (!o_res.latch_clock && !o_res.shift_clock &&
             o_res.active_column == COL_OUT_W'(COLUMN_COUNT - 1)))
        else $error("frame end outside the last column latch");

endmodule

// ===== sv/lmcs_scan_core.sv =====
// Scan state machine, BCD counter and dwell register of the column scanner.
// Depends on lmcs_pkg for the phase codes, result type and glyph ROM.
module lmcs_scan_core import lmcs_pkg::*; #(
    parameter int COLUMN_COUNT = 32,
    parameter int DIGIT_COUNT  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [DWELL_W-1:0]  i_cfg_data,
    input  logic                i_accept,
    input  logic                i_advance,
    output t_lmcs_res           o_res
);

    localparam int CW      = $clog2(COLUMN_COUNT);
    localparam int DIW     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int VAL_MAX = 10 ** DIGIT_COUNT - 1;
    localparam int VW      = $clog2(VAL_MAX + 1);

    localparam logic [CW-1:0] COL_LAST = CW'(COLUMN_COUNT - 1);
    localparam logic [VW-1:0] VAL_LAST = VW'(VAL_MAX);

    logic [DWELL_W-1:0] r_dwell_ticks;
    logic [3:0]         r_digit [DIGIT_COUNT];
    logic [3:0]         n_digit [DIGIT_COUNT];
    logic [VW-1:0]      r_value, n_value;
    logic [CW-1:0]      r_col, n_col;
    logic [CW-1:0]      r_bit, n_bit;
    t_phase             r_phase, n_phase;
    logic               r_half, n_half;
    logic [DWELL_W-1:0] r_dwell, n_dwell;
    logic [ROW_W-1:0]   r_row, n_row;

    logic [ROW_W-1:0]   glyph;
    logic [31:0]        matrix;
    logic [DWELL_W-1:0] limit;
    logic               step;
    logic               data, sclk, lclk, done;

    always_comb begin
        matrix = 32'(r_col) >> 3;
        if (matrix < 32'(DIGIT_COUNT)) begin
            glyph = glyph_line(r_digit[matrix[DIW-1:0]], r_col[2:0]);
        end else begin
            glyph = ROW_BLANK;
        end
    end

    // ripple the BCD carry from the least significant digit
    always_comb begin
        logic carry;
        carry = step;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
            if (carry && r_digit[i] >= DIGIT_MAX) begin
                n_digit[i] = 4'd0;
            end else if (carry) begin
                n_digit[i] = r_digit[i] + 4'd1;
                carry = 1'b0;
            end else begin
                n_digit[i] = r_digit[i];
            end
        end
    end

    assign limit = (r_dwell_ticks == '0) ? DWELL_W'(1) : r_dwell_ticks;

    always_comb begin
        n_col   = r_col;
        n_bit   = r_bit;
        n_phase = r_phase;
        n_half  = r_half;
        n_dwell = r_dwell;
        n_row   = r_row;
        n_value = r_value;
        step    = 1'b0;
        data    = 1'b0;
        sclk    = 1'b0;
        lclk    = 1'b0;
        done    = 1'b0;
        if (i_accept && i_advance) begin
            case (r_phase)
                PH_SEL_LATCH: begin
                    lclk = !r_half;
                    n_half = !r_half;
                    if (r_half) begin
                        n_row   = glyph;
                        n_dwell = '0;
                        n_phase = PH_DWELL;
                    end
                end
                PH_DWELL: begin
                    if ({1'b0, r_dwell} + 17'd1 >= {1'b0, limit}) begin
                        n_dwell = '0;
                        n_bit   = '0;
                        n_half  = 1'b0;
                        n_phase = PH_BLK_SHIFT;
                    end else begin
                        n_dwell = r_dwell + DWELL_W'(1);
                    end
                end
                PH_BLK_SHIFT: begin
                    sclk = !r_half;
                    n_half = !r_half;
                    if (r_half) begin
                        if (r_bit == COL_LAST) begin
                            n_bit   = '0;
                            n_phase = PH_BLK_LATCH;
                        end else begin
                            n_bit = r_bit + CW'(1);
                        end
                    end
                end
                PH_BLK_LATCH: begin
                    lclk = !r_half;
                    n_half = !r_half;
                    if (r_half) begin
                        n_row   = ROW_BLANK;
                        n_phase = PH_SEL_SHIFT;
                        n_bit   = '0;
                        if (r_col == COL_LAST) begin
                            done  = 1'b1;
                            step  = 1'b1;
                            n_col = '0;
                            n_value = (r_value == VAL_LAST) ? '0 : r_value + VW'(1);
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                end
                default: begin
                    n_phase = PH_SEL_SHIFT;
                    data = (r_bit == r_col);
                    sclk = !r_half;
                    n_half = !r_half;
                    if (r_half) begin
                        if (r_bit == COL_LAST) begin
                            n_bit   = '0;
                            n_phase = PH_SEL_LATCH;
                        end else begin
                            n_bit = r_bit + CW'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= DWELL_RESET;
            r_col   <= '0;
            r_bit   <= '0;
            r_phase <= PH_SEL_SHIFT;
            r_half  <= 1'b0;
            r_dwell <= '0;
            r_row   <= ROW_BLANK;
            r_value <= '0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_digit[i] <= 4'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_dwell_ticks <= i_cfg_data;
            end
            r_col   <= n_col;
            r_bit   <= n_bit;
            r_phase <= n_phase;
            r_half  <= n_half;
            r_dwell <= n_dwell;
            r_row   <= n_row;
            r_value <= n_value;
            r_digit <= n_digit;
        end
    end

    always_comb begin
        o_res.serial_data   = data;
        o_res.shift_clock   = sclk;
        o_res.latch_clock   = lclk;
        o_res.row_drive     = n_row;
        o_res.active_column = COL_OUT_W'(r_col);
        o_res.shown_value   = SHOWN_W'(r_value);
        o_res.frame_done    = done;
    end

endmodule

// ===== sv/lmcs_skid.sv =====
// Two-entry output buffer (result register plus skid register) for scanner results.
// Depends on lmcs_pkg for the result type.
module lmcs_skid import lmcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_lmcs_res i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_lmcs_res o_data
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_lmcs_res r_out;
    t_lmcs_res r_skid;
    logic      take;
    logic      fill;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign take    = r_out_valid && i_ready;
    assign fill    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (fill) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill) begin
            if (!r_out_valid || take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule
